FILE: design/smd_pkg.sv
`default_nettype none
package smd_pkg;

    localparam int DELAY_DEPTH = 131072;
    localparam int ADDR_W      = $clog2(DELAY_DEPTH);
    localparam int MAX_TAPS    = 5;

    // reciprocal scaling for the delay divide
    localparam int RECIP_SHIFT = 22;
    localparam int RECIP_W     = 23;
    localparam int NUM_W       = 18;
    localparam int PROD_W      = NUM_W + RECIP_W;

    localparam logic [1:0] REG_SAMPLE_RATE = 2'd0;
    localparam logic [1:0] REG_DELAY_TIME  = 2'd1;
    localparam logic [1:0] REG_TAP_COUNT   = 2'd2;
    localparam logic [1:0] REG_MIX_GAIN    = 2'd3;

    localparam logic [16:0] SAMPLE_RATE_RST = 17'd48000;
    localparam logic [3:0]  DELAY_TIME_RST  = 4'd1;
    localparam logic [2:0]  TAP_COUNT_RST   = 3'd1;
    localparam logic [15:0] MIX_GAIN_RST    = 16'd0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_TAPS,
        ST_DRAIN,
        ST_MIX,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic clear;
        logic acc;
        logic mul;
    } lane_ctl_t;

    // ceil(2^22 / div) for the divisors that can occur
    function automatic logic [RECIP_W-1:0] recip(input logic [3:0] div);
        logic [RECIP_W-1:0] m;
        case (div)
            4'd1:    m = 23'd4194304;
            4'd2:    m = 23'd2097152;
            4'd3:    m = 23'd1398102;
            4'd4:    m = 23'd1048576;
            4'd5:    m = 23'd838861;
            4'd6:    m = 23'd699051;
            4'd7:    m = 23'd599187;
            4'd8:    m = 23'd524288;
            4'd9:    m = 23'd466034;
            4'd10:   m = 23'd419431;
            4'd11:   m = 23'd381301;
            4'd12:   m = 23'd349526;
            default: m = 23'd349526;
        endcase
        return m;
    endfunction

endpackage
`default_nettype wire

FILE: design/smd_ram.sv
`default_nettype none
module smd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

FILE: design/smd_tap_addr.sv
`default_nettype none
module smd_tap_addr import smd_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              issue,
    input  wire logic [2:0]        tap,
    input  wire logic [16:0]       sample_rate,
    input  wire logic [3:0]        div_base,
    input  wire logic [ADDR_W-1:0] wi,
    input  wire logic              wrapped,
    output logic                   ram_re,
    output logic      [ADDR_W-1:0] ram_raddr,
    output logic                   acc_valid,
    output logic                   acc_keep,
    output logic                   busy
);

    localparam logic [18:0]       DMAX    = 19'(DELAY_DEPTH - 1);
    localparam logic [ADDR_W:0]   DEPTH_X = (ADDR_W + 1)'(DELAY_DEPTH);

    logic [3:0]        div;
    logic [NUM_W-1:0]  num;
    logic [PROD_W-1:0] prod_next, prod_reg;
    logic              v1_reg, v2_reg, ok2_reg;
    logic [18:0]       quo;
    logic [ADDR_W-1:0] dly;
    logic [ADDR_W:0]   wrap_sum;
    logic [ADDR_W-1:0] ri;
    logic              ok;

    // taps share a divisor in pairs (0-1, 2-3); tap 4 has its own
    assign div       = div_base + {2'b00, tap[2:1]};
    assign num       = {1'b0, sample_rate} + {14'd0, div} - 18'd1;
    assign prod_next = PROD_W'(num * recip(div));

    assign quo      = prod_reg[PROD_W-1:RECIP_SHIFT];
    assign dly      = (quo > DMAX) ? DMAX[ADDR_W-1:0] : quo[ADDR_W-1:0];
    assign wrap_sum = {1'b0, wi} + DEPTH_X - {1'b0, dly};
    assign ri       = (dly > wi) ? wrap_sum[ADDR_W-1:0] : (wi - dly);
    // entries never written since reset read as zero
    assign ok       = wrapped || (ri <= wi);

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            prod_reg <= prod_next;
        end
        ok2_reg <= ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= issue;
            v2_reg <= v1_reg;
        end
    end

    assign ram_re    = v1_reg;
    assign ram_raddr = ri;
    assign acc_valid = v2_reg;
    assign acc_keep  = ok2_reg;
    assign busy      = v1_reg | v2_reg;

endmodule
`default_nettype wire

FILE: design/smd_lane.sv
`default_nettype none
module smd_lane import smd_pkg::*; (
    input  wire logic         clk,
    input  wire lane_ctl_t    ctl,
    input  wire logic [15:0]  dry_in,
    input  wire logic [15:0]  tap_sample,
    input  wire logic [15:0]  gain,
    output logic      [15:0]  result
);

    logic signed [15:0] dry_reg;
    logic signed [18:0] sum_reg;
    logic signed [35:0] prod_reg;
    logic signed [35:0] rnd;
    logic signed [19:0] scaled;
    logic signed [20:0] total;

    always_ff @(posedge clk)
    begin
        if (ctl.clear)
        begin
            dry_reg <= $signed(dry_in);
            sum_reg <= 19'sd0;
        end
        else if (ctl.acc)
        begin
            sum_reg <= sum_reg + 19'($signed(tap_sample));
        end
        if (ctl.mul)
        begin
            prod_reg <= 36'(sum_reg * $signed({1'b0, gain}));
        end
    end

    // round half up, then add the dry sample and clip
    assign rnd    = prod_reg + 36'sd32768;
    assign scaled = 20'(rnd >>> 16);
    assign total  = 21'(dry_reg) + 21'(scaled);

    always_comb
    begin
        if (total > 21'sd32767)
        begin
            result = 16'h7fff;
        end
        else if (total < -21'sd32768)
        begin
            result = 16'h8000;
        end
        else
        begin
            result = total[15:0];
        end
    end

endmodule
`default_nettype wire

FILE: design/smd_merge.sv
`default_nettype none
module smd_merge (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        load,
    input  wire logic [15:0] left_res,
    input  wire logic [15:0] right_res,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata
);

    logic        valid_reg;
    logic [31:0] data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= {right_res, left_res};
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule
`default_nettype wire

FILE: design/stereo_multitap_delay_core.sv
`default_nettype none
// Channel   Direction  Bits  Content
// s_axis    in         32    left_in [15:0], right_in [31:16]
// m_axis    out        32    left_out [15:0], right_out [31:16]
// apb       in/out     32    sample_rate, delay_time, tap_count, mix_gain at 0x0..0xc
//
// From acceptance to the result register, one word passes through one write into the
// delay RAM, one read issue per tap, then a three-stage tail (divide multiply, RAM
// read, accumulate) and the gain multiply in each lane.
// The delay RAM is not swept after reset: reads behind the fill point return zero.
// A held result blocks only the final load; the next word is taken once it leaves.
module stereo_multitap_delay_core import smd_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // left_in [15:0], right_in [31:16]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // left_out [15:0], right_out [31:16]
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    logic [16:0] sample_rate_reg;
    logic [3:0]  delay_time_reg;
    logic [2:0]  tap_count_reg;
    logic [15:0] mix_gain_reg;
    logic        cfg_we;

    state_t      state_reg, state_next;
    logic [2:0]  k_reg, k_next;
    logic [ADDR_W-1:0] wi_reg, wi_next;
    logic        wrapped_reg, wrapped_next;
    logic [31:0] dry_reg;

    logic [3:0]  t_clamp;
    logic [3:0]  div_base;
    logic [2:0]  taps;
    logic        accept;
    logic        issue;
    logic        ram_we;
    logic        ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [31:0] ram_rdata;
    logic        acc_valid, acc_keep, busy;
    logic [31:0] tap_word;
    lane_ctl_t   lane_ctl;
    logic [15:0] left_res, right_res;
    logic        out_load;

    // configuration
    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_rate_reg <= SAMPLE_RATE_RST;
            delay_time_reg  <= DELAY_TIME_RST;
            tap_count_reg   <= TAP_COUNT_RST;
            mix_gain_reg    <= MIX_GAIN_RST;
        end
        else if (cfg_we)
        begin
            case (paddr[3:2])
                REG_SAMPLE_RATE: sample_rate_reg <= pwdata[16:0];
                REG_DELAY_TIME:  delay_time_reg  <= pwdata[3:0];
                REG_TAP_COUNT:   tap_count_reg   <= pwdata[2:0];
                REG_MIX_GAIN:    mix_gain_reg    <= pwdata[15:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_SAMPLE_RATE: prdata = {15'd0, sample_rate_reg};
            REG_DELAY_TIME:  prdata = {28'd0, delay_time_reg};
            REG_TAP_COUNT:   prdata = {29'd0, tap_count_reg};
            REG_MIX_GAIN:    prdata = {16'd0, mix_gain_reg};
            default:         prdata = 32'd0;
        endcase
    end

    always_comb
    begin
        if (delay_time_reg == 4'd0)
        begin
            t_clamp = 4'd1;
        end
        else if (delay_time_reg > 4'd10)
        begin
            t_clamp = 4'd10;
        end
        else
        begin
            t_clamp = delay_time_reg;
        end
    end

    assign div_base = 4'd11 - t_clamp;
    assign taps     = (tap_count_reg > 3'(MAX_TAPS)) ? 3'(MAX_TAPS) : tap_count_reg;

    // sequencer
    assign accept = s_tvalid & s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            k_reg       <= 3'd0;
            wi_reg      <= '0;
            wrapped_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            k_reg       <= k_next;
            wi_reg      <= wi_next;
            wrapped_reg <= wrapped_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dry_reg <= s_tdata;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        wi_next        = wi_reg;
        wrapped_next   = wrapped_reg;
        s_tready       = 1'b0;
        ram_we         = 1'b0;
        issue          = 1'b0;
        lane_ctl.clear = 1'b0;
        lane_ctl.acc   = acc_valid;
        lane_ctl.mul   = 1'b0;
        out_load       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    lane_ctl.clear = 1'b1;
                    state_next     = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                ram_we     = 1'b1;
                k_next     = 3'd0;
                state_next = ST_TAPS;
            end
            ST_TAPS:
            begin
                issue  = (k_reg < taps);
                k_next = k_reg + 3'd1;
                if ({1'b0, k_reg} + 4'd1 >= {1'b0, taps})
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!busy)
                begin
                    state_next = ST_MIX;
                end
            end
            ST_MIX:
            begin
                lane_ctl.mul = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT:
            begin
                // hold until the output register is free
                if (!m_tvalid || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                    if (wi_reg == ADDR_W'(DELAY_DEPTH - 1))
                    begin
                        wi_next      = '0;
                        wrapped_next = 1'b1;
                    end
                    else
                    begin
                        wi_next = wi_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign tap_word = acc_keep ? ram_rdata : 32'd0;

    smd_ram #(
        .WIDTH (32),
        .DEPTH (DELAY_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wi_reg),
        .wdata (dry_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    smd_tap_addr u_tap (
        .clk         (clk),
        .rst_n       (rst_n),
        .issue       (issue),
        .tap         (k_reg),
        .sample_rate (sample_rate_reg),
        .div_base    (div_base),
        .wi          (wi_reg),
        .wrapped     (wrapped_reg),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .acc_valid   (acc_valid),
        .acc_keep    (acc_keep),
        .busy        (busy)
    );

    smd_lane u_lane_left (
        .clk        (clk),
        .ctl        (lane_ctl),
        .dry_in     (s_tdata[15:0]),
        .tap_sample (tap_word[15:0]),
        .gain       (mix_gain_reg),
        .result     (left_res)
    );

    smd_lane u_lane_right (
        .clk        (clk),
        .ctl        (lane_ctl),
        .dry_in     (s_tdata[31:16]),
        .tap_sample (tap_word[31:16]),
        .gain       (mix_gain_reg),
        .result     (right_res)
    );

    smd_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (out_load),
        .left_res  (left_res),
        .right_res (right_res),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
`default_nettype wire

FILE: bench/tb.sv
module tb;
    import smd_pkg::*;

    localparam int DRAIN_GAP = 16;
    localparam int WORDS_PER_PHASE = 100;

    typedef struct packed {
        logic [15:0] right;
        logic [15:0] left;
    } stereo_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // left_in [15:0], right_in [31:16]
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // left_out [15:0], right_out [31:16]
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    stereo_multitap_delay_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // mirror of the block's registers and delay memory
    logic [16:0] cfg_rate  = SAMPLE_RATE_RST;
    logic [3:0]  cfg_time  = DELAY_TIME_RST;
    logic [2:0]  cfg_taps  = TAP_COUNT_RST;
    logic [15:0] cfg_gain  = MIX_GAIN_RST;
    bit   [31:0] echo_mem [DELAY_DEPTH];
    logic [16:0] wr_ptr    = '0;

    stereo_t pending_mix[$];
    int      err_count     = 0;
    int      send_idle_pct = 0;
    int      stall_pct     = 0;
    int      hold_left     = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("stereo_multitap_delay_core test failed");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        err_count++;
    endtask

    function automatic int tap_delay_of(input int k);
        int t;
        int dv;
        int d;
        t = int'(cfg_time);
        if (t < 1) t = 1;
        if (t > 10) t = 10;
        dv = 11 - t + k / 2;
        d = (int'(cfg_rate) + dv - 1) / dv;
        if (d > DELAY_DEPTH - 1) d = DELAY_DEPTH - 1;
        return d;
    endfunction

    // round half up from Q.16, add the dry sample, saturate
    function automatic logic [15:0] blend(input logic [15:0] dry, input int tapsum);
        longint prod;
        longint s;
        prod = longint'(tapsum) * longint'(cfg_gain) + 64'sd32768;
        s = longint'($signed(dry)) + (prod >>> 16);
        if (s > 32767) s = 32767;
        if (s < -32768) s = -32768;
        return s[15:0];
    endfunction

    function automatic stereo_t predict_mix(input stereo_t w);
        int          lsum;
        int          rsum;
        int          ntaps;
        logic [16:0] rd;
        stereo_t     tap;
        stereo_t     r;
        lsum = 0;
        rsum = 0;
        ntaps = (cfg_taps > 3'd5) ? 5 : int'(cfg_taps);
        echo_mem[wr_ptr] = w;
        for (int k = 0; k < ntaps; k++)
        begin
            rd = wr_ptr - 17'(tap_delay_of(k));
            tap = echo_mem[rd];
            lsum += $signed(tap.left);
            rsum += $signed(tap.right);
        end
        r.left  = blend(w.left, lsum);
        r.right = blend(w.right, rsum);
        wr_ptr = wr_ptr + 17'd1;
        return r;
    endfunction

    function automatic logic [31:0] reg_value(input logic [1:0] idx);
        case (idx)
            REG_SAMPLE_RATE: return {15'd0, cfg_rate};
            REG_DELAY_TIME:  return {28'd0, cfg_time};
            REG_TAP_COUNT:   return {29'd0, cfg_taps};
            default:         return {16'd0, cfg_gain};
        endcase
    endfunction

    // receiver: random stalls, or a counted hold-off when one is requested
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
                m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        stereo_t got;
        stereo_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (pending_mix.size() == 0)
                report_mismatch($sformatf("unexpected word %h", got));
            else
            begin
                want = pending_mix.pop_front();
                if (got.left !== want.left)
                    report_mismatch($sformatf("left_out %h, want %h", got.left, want.left));
                if (got.right !== want.right)
                    report_mismatch($sformatf("right_out %h, want %h", got.right, want.right));
            end
        end
    end

    // all tasks below start and end at a falling edge
    task automatic send_word(input stereo_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        pending_mix.push_back(predict_mix(w));
        @(negedge clk);
    endtask

    function automatic logic [15:0] pick_extreme();
        case ($urandom_range(3))
            0:       return 16'h7fff;
            1:       return 16'h8000;
            2:       return 16'h0000;
            default: return 16'hffff;
        endcase
    endfunction

    task automatic send_random(input int n);
        stereo_t w;
        repeat (n)
        begin
            w = $urandom;
            if ($urandom_range(7) == 0) w.left = pick_extreme();
            if ($urandom_range(7) == 0) w.right = pick_extreme();
            send_word(w);
        end
    endtask

    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        while (pending_mix.size() != 0) @(negedge clk);
        repeat (DRAIN_GAP) @(negedge clk);
    endtask

    task automatic check_reg(input logic [1:0] idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (prdata !== reg_value(idx))
            report_mismatch($sformatf("register %0d reads %h, want %h",
                                      idx, prdata, reg_value(idx)));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_reg(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        case (idx)
            REG_SAMPLE_RATE: cfg_rate = val[16:0];
            REG_DELAY_TIME:  cfg_time = val[3:0];
            REG_TAP_COUNT:   cfg_taps = val[2:0];
            default:         cfg_gain = val[15:0];
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        check_reg(idx);
    endtask

    task automatic configure(input int rate, input int dtime, input int taps, input int gain);
        drain_pipeline();
        set_reg(REG_SAMPLE_RATE, rate);
        set_reg(REG_DELAY_TIME, dtime);
        set_reg(REG_TAP_COUNT, taps);
        set_reg(REG_MIX_GAIN, gain);
    endtask

    task automatic set_idling(input int sender, input int receiver);
        send_idle_pct = sender;
        stall_pct     = receiver;
    endtask

    task automatic test_reset_state();
        check_reg(REG_SAMPLE_RATE);
        check_reg(REG_DELAY_TIME);
        check_reg(REG_TAP_COUNT);
        check_reg(REG_MIX_GAIN);
        send_word({16'h8000, 16'h7fff});
        send_word({16'h7fff, 16'h8000});
        send_word({16'hffff, 16'h0000});
        send_word({16'h0000, 16'hffff});
    endtask

    // short delays so that five full-scale taps drive both rails
    task automatic test_tap_saturation();
        configure(4, 10, 5, 58982);
        repeat (4) send_word({16'h8000, 16'h7fff});
        repeat (4) send_word({16'h7fff, 16'h8000});
        send_word({16'h0000, 16'h0000});
        send_word({16'hffff, 16'h0001});
    endtask

    // delay time below and above range, tap count above five and zero, gain above 0.9
    task automatic test_out_of_range_settings();
        configure(30, 0, 7, 65535);
        send_random(3);
        configure(30, 15, 6, 65535);
        send_random(3);
        configure(30, 5, 0, 65535);
        send_random(2);
    endtask

    task automatic test_zero_and_full_delay();
        configure(0, 15, 3, 32768);
        send_random(3);
        configure(131071, 10, 5, 58982);
        send_random(2);
    endtask

    // hold the output off long enough for the block to stall its input
    task automatic test_input_stall();
        configure(12, 7, 5, 40000);
        set_idling(0, 0);
        @(posedge clk);
        hold_left = 300;
        @(negedge clk);
        send_random(40);
        drain_pipeline();
        send_random(20);
    endtask

    task automatic test_random_stream();
        int rate;
        int gain;
        for (int p = 0; p < 8; p++)
        begin
            case ($urandom_range(9))
                0:       rate = 0;
                1:       rate = 131071;
                2:       rate = $urandom_range(96000, 8000);
                default: rate = $urandom_range(120, 1);
            endcase
            case ($urandom_range(4))
                0:       gain = 0;
                1:       gain = 65535;
                default: gain = $urandom_range(58982);
            endcase
            configure(rate, $urandom_range(15), $urandom_range(7), gain);
            case (p % 4)
                0:       set_idling(0, 0);
                1:       set_idling(54, 0);
                2:       set_idling(0, 54);
                default: set_idling(28, 28);
            endcase
            send_random(WORDS_PER_PHASE);
        end
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_state();
        test_tap_saturation();
        test_out_of_range_settings();
        test_zero_and_full_delay();
        test_input_stall();
        test_random_stream();

        drain_pipeline();
        if (err_count == 0)
            $display("stereo_multitap_delay_core test passed");
        else
            $display("stereo_multitap_delay_core test failed");
        $finish;
    end

endmodule
